// ===== hw/rtl/fdr_pkg.sv =====
// Shared sizes and word layouts for the frame deframer.
// No dependencies; imported by frame_deframer_resync.
package fdr_pkg;

   localparam int RING_DEPTH  = 2048;
   localparam int MAX_PAYLOAD = 768;
   localparam int HDR_BYTES   = 8;

   localparam int RING_AW = $clog2(RING_DEPTH);
   localparam int PLEN_W  = $clog2(MAX_PAYLOAD + 1);
   localparam int CNT_W   = (PLEN_W > 3) ? PLEN_W : 3;
   localparam int PAY_AW  = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
   localparam int CMP_W   = ((RING_AW > 16) ? RING_AW : 16) + 1;

   localparam int FLEN_W     = 10;
   localparam int CSR_AW     = 2;
   localparam int CSR_DW     = 8;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 24;

   localparam logic [CSR_AW-1:0] CSR_FIRST_PREFIX  = 2'd0;
   localparam logic [CSR_AW-1:0] CSR_SECOND_PREFIX = 2'd1;

   localparam logic [7:0] FIRST_PREFIX_RST  = 8'd170;
   localparam logic [7:0] SECOND_PREFIX_RST = 8'd85;

   localparam logic KIND_RX   = 1'b0;
   localparam logic KIND_READ = 1'b1;

   typedef logic [RING_AW-1:0] ring_addr_type;

endpackage

// ===== hw/rtl/frame_deframer_resync.sv =====
// Byte-stream deframer with resync: ring store, header check, sum, payload copy.
// Uses fdr_pkg; one sequencer drives one ring read port and one 16-bit adder.
// A read word returns the next copied payload byte, if one is left; a received word is
// stored, then each header try is read and dropped, summed and dropped on a checksum
// miss, left to wait for more bytes, or summed and copied into the payload store on accept.
// One word in work at a time; reset clears indices, the accepted length and overflow, and loads the prefix defaults.
module frame_deframer_resync (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [fdr_pkg::REQ_DATA_W-1:0] req_tdata,   // [7:0] rx_byte
   input  logic                           req_tuser,   // [0] kind
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [0] frame_ready, [10:1] frame_length, [11] payload_valid,
   // [19:12] payload_byte, [20] overflow, [23:21] zero
   output logic [fdr_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                           rsp_tlast,   // payload_last
   input  logic                           csr_we,
   input  logic [fdr_pkg::CSR_AW-1:0]     csr_addr,
   input  logic [fdr_pkg::CSR_DW-1:0]     csr_wdata
);
   import fdr_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_SCAN = 4'd1;
   localparam logic [3:0] S_HRD  = 4'd2;
   localparam logic [3:0] S_HCAP = 4'd3;
   localparam logic [3:0] S_CHK  = 4'd4;
   localparam logic [3:0] S_SRD  = 4'd5;
   localparam logic [3:0] S_SCAP = 4'd6;
   localparam logic [3:0] S_SCHK = 4'd7;
   localparam logic [3:0] S_CRD  = 4'd8;
   localparam logic [3:0] S_CCAP = 4'd9;
   localparam logic [3:0] S_ACC  = 4'd10;
   localparam logic [3:0] S_PRD  = 4'd11;
   localparam logic [3:0] S_OUT  = 4'd12;

   localparam ring_addr_type RING_MAX = ring_addr_type'(RING_DEPTH - 1);

   logic [7:0] ring_mem [RING_DEPTH];
   logic [7:0] pay_mem  [MAX_PAYLOAD];

   logic [3:0]        state_ff, state_in;
   logic [7:0]        fp_ff, fp_in, sp_ff, sp_in;
   ring_addr_type     wr_ff, wr_in, scan_ff, scan_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [7:0]        hdr_ff [HDR_BYTES];
   logic [15:0]       sum_ff, sum_in;
   logic [PLEN_W-1:0] plen_ff, plen_in, acc_ff, acc_in, rdi_ff, rdi_in;
   logic              ovf_ff, ovf_in;
   logic [7:0]        ring_q_ff, pay_q_ff;
   // pending result
   logic              p_rdy_ff, p_rdy_in, p_pv_ff, p_pv_in, p_pl_ff, p_pl_in;
   logic [PLEN_W-1:0] p_len_ff, p_len_in;
   logic [7:0]        p_pb_ff, p_pb_in;
   // output register
   logic                  rv_ff, rv_in, rl_ff, rl_in;
   logic [RSP_DATA_W-1:0] rd_ff, rd_in;

   ring_addr_type raddr, buffered;
   logic          ring_we, hdr_we, pay_we, acc_rx;
   logic [15:0]   plen16, want;
   logic [CMP_W-1:0] need;

   assign buffered = wr_ff - scan_ff;
   assign plen16   = {hdr_ff[4], hdr_ff[3]};
   assign want     = {hdr_ff[7], hdr_ff[6]};
   assign need     = CMP_W'(plen16) + CMP_W'(HDR_BYTES);
   assign req_tready = (state_ff == S_IDLE);
   assign acc_rx   = req_tvalid && req_tready && (req_tuser == KIND_RX);
   assign ring_we  = acc_rx && (buffered != RING_MAX);
   assign hdr_we   = (state_ff == S_HCAP);
   assign pay_we   = (state_ff == S_CCAP);

   always_comb begin
      if (state_ff == S_HRD || state_ff == S_HCAP) begin
         raddr = scan_ff + ring_addr_type'(cnt_ff);
      end else begin
         raddr = scan_ff + ring_addr_type'(HDR_BYTES) + ring_addr_type'(cnt_ff);
      end
   end

   always_comb begin
      state_in = state_ff;
      fp_in    = fp_ff;
      sp_in    = sp_ff;
      wr_in    = wr_ff;
      scan_in  = scan_ff;
      cnt_in   = cnt_ff;
      sum_in   = sum_ff;
      plen_in  = plen_ff;
      acc_in   = acc_ff;
      rdi_in   = rdi_ff;
      ovf_in   = ovf_ff;
      p_rdy_in = p_rdy_ff;
      p_len_in = p_len_ff;
      p_pv_in  = p_pv_ff;
      p_pb_in  = p_pb_ff;
      p_pl_in  = p_pl_ff;
      rv_in    = rv_ff && !rsp_tready;
      rd_in    = rd_ff;
      rl_in    = rl_ff;

      if (csr_we) begin
         if (csr_addr == CSR_FIRST_PREFIX) fp_in = csr_wdata;
         if (csr_addr == CSR_SECOND_PREFIX) sp_in = csr_wdata;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               p_rdy_in = 1'b0;
               p_len_in = '0;
               p_pv_in  = 1'b0;
               p_pb_in  = '0;
               p_pl_in  = 1'b0;
               if (req_tuser == KIND_RX) begin
                  if (buffered == RING_MAX) begin
                     ovf_in = 1'b1;
                  end else begin
                     wr_in = wr_ff + 1'b1;
                  end
                  rdi_in   = '0;
                  state_in = S_SCAN;
               end else if (rdi_ff < acc_ff) begin
                  state_in = S_PRD;
               end else begin
                  state_in = S_OUT;
               end
            end
         end
         S_PRD: begin
            // payload word for rdi_ff is now in pay_q_ff
            p_pv_in  = 1'b1;
            p_pb_in  = pay_q_ff;
            p_pl_in  = (rdi_ff + 1'b1 == acc_ff);
            rdi_in   = rdi_ff + 1'b1;
            state_in = S_OUT;
         end
         S_SCAN: begin
            cnt_in = '0;
            if (buffered > ring_addr_type'(HDR_BYTES - 1)) begin
               state_in = S_HRD;
            end else begin
               acc_in   = '0;
               state_in = S_OUT;
            end
         end
         S_HRD:  state_in = S_HCAP;
         S_HCAP: begin
            cnt_in   = cnt_ff + 1'b1;
            state_in = (cnt_ff == CNT_W'(HDR_BYTES - 1)) ? S_CHK : S_HRD;
         end
         S_CHK: begin
            cnt_in  = '0;
            sum_in  = '0;
            plen_in = PLEN_W'(plen16);
            priority if (hdr_ff[0] != fp_ff) begin
               scan_in  = scan_ff + 1'b1;
               state_in = S_SCAN;
            end else if (hdr_ff[1] != sp_ff || (hdr_ff[3] ^ hdr_ff[4]) != hdr_ff[5] ||
                         plen16 > 16'(MAX_PAYLOAD)) begin
               scan_in  = scan_ff + ring_addr_type'(2);
               state_in = S_SCAN;
            end else if (need > CMP_W'(buffered)) begin
               acc_in   = '0;
               state_in = S_OUT;
            end else if (plen16 == 16'd0) begin
               state_in = S_SCHK;
            end else begin
               state_in = S_SRD;
            end
         end
         S_SRD:  state_in = S_SCAP;
         S_SCAP: begin
            sum_in   = sum_ff + 16'(ring_q_ff);
            cnt_in   = cnt_ff + 1'b1;
            state_in = (cnt_ff + 1'b1 == CNT_W'(plen_ff)) ? S_SCHK : S_SRD;
         end
         S_SCHK: begin
            cnt_in = '0;
            if (sum_ff != want) begin
               scan_in  = scan_ff + ring_addr_type'(2);
               state_in = S_SCAN;
            end else begin
               state_in = (plen_ff == '0) ? S_ACC : S_CRD;
            end
         end
         S_CRD:  state_in = S_CCAP;
         S_CCAP: begin
            cnt_in   = cnt_ff + 1'b1;
            state_in = (cnt_ff + 1'b1 == CNT_W'(plen_ff)) ? S_ACC : S_CRD;
         end
         S_ACC: begin
            scan_in  = scan_ff + ring_addr_type'(plen_ff) + ring_addr_type'(HDR_BYTES);
            acc_in   = plen_ff;
            p_rdy_in = 1'b1;
            p_len_in = plen_ff;
            state_in = S_OUT;
         end
         S_OUT: begin
            // hold until the output register is free
            if (!rv_ff || rsp_tready) begin
               rv_in = 1'b1;
               rd_in = '0;
               rd_in[0]     = p_rdy_ff;
               rd_in[10:1]  = FLEN_W'(p_len_ff);
               rd_in[11]    = p_pv_ff;
               rd_in[19:12] = p_pb_ff;
               rd_in[20]    = ovf_ff;
               rl_in        = p_pl_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ring_we) ring_mem[wr_ff] <= req_tdata;
      ring_q_ff <= ring_mem[raddr];
      if (pay_we) pay_mem[PAY_AW'(cnt_ff)] <= ring_q_ff;
      pay_q_ff <= pay_mem[PAY_AW'(rdi_ff)];
      if (hdr_we) hdr_ff[cnt_ff[2:0]] <= ring_q_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fp_ff    <= FIRST_PREFIX_RST;
         sp_ff    <= SECOND_PREFIX_RST;
         wr_ff    <= '0;
         scan_ff  <= '0;
         acc_ff   <= '0;
         rdi_ff   <= '0;
         ovf_ff   <= 1'b0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         fp_ff    <= fp_in;
         sp_ff    <= sp_in;
         wr_ff    <= wr_in;
         scan_ff  <= scan_in;
         acc_ff   <= acc_in;
         rdi_ff   <= rdi_in;
         ovf_ff   <= ovf_in;
         rv_ff    <= rv_in;
      end
      cnt_ff   <= cnt_in;
      sum_ff   <= sum_in;
      plen_ff  <= plen_in;
      p_rdy_ff <= p_rdy_in;
      p_len_ff <= p_len_in;
      p_pv_ff  <= p_pv_in;
      p_pb_ff  <= p_pb_in;
      p_pl_ff  <= p_pl_in;
      rd_ff    <= rd_in;
      rl_ff    <= rl_in;
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = rd_ff;
   assign rsp_tlast  = rl_ff;

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("sequencer took a word while busy");
   a_read_bound: assert property (@(posedge clock) disable iff (reset)
      rdi_ff <= acc_ff)
      else $error("payload read index beyond accepted length");
   a_kind_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[11] |-> !rsp_tdata[0])
      else $error("payload word also flagged frame ready");
   a_ovf_sticky: assert property (@(posedge clock) disable iff (reset)
      $past(ovf_ff) |-> ovf_ff)
      else $error("overflow flag cleared");
`endif

endmodule
